[hw/rtl/scmg_pkg.sv]
`timescale 1ns / 1ps

package scmg_pkg;

   // value format: one integer bit above FRAC_BITS fraction bits
   localparam int FRAC_BITS   = 31;
   localparam int VAL_W       = FRAC_BITS + 1;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int LOGI_SHIFT  = FRAC_BITS - 2;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = 32;

   localparam logic [VAL_W-1:0] VAL_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VAL_W-1:0] VAL_HALF = VAL_ONE >> 1;

   localparam logic [VAL_W-1:0]   BREAKPOINT_RESET    = VAL_W'(1095216660);
   localparam logic [RECIP_W-1:0] INV_BREAKPOINT_RESET = RECIP_W'(526344031);
   localparam logic [RECIP_W-1:0] INV_COMPLEMENT_RESET = RECIP_W'(547827461);

   typedef enum logic [2:0] {
      MODE_LOGISTIC       = 3'd0,
      MODE_TENT           = 3'd1,
      MODE_SKEW_TENT      = 3'd2,
      MODE_ALTERNATE      = 3'd3,
      MODE_TENT_LOGISTIC  = 3'd4,
      MODE_LOGISTIC_TENT  = 3'd5
   } map_mode_type;

   typedef enum logic [1:0] {
      CSR_MAP_MODE        = 2'd0,
      CSR_SKEW_BREAKPOINT = 2'd1,
      CSR_INV_BREAKPOINT  = 2'd2,
      CSR_INV_COMPLEMENT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      map_mode_type          mode;
      logic [VAL_W-1:0]      breakpoint;
      logic [RECIP_W-1:0]    inv_breakpoint;
      logic [RECIP_W-1:0]    inv_complement;
   } cfg_type;

   // tent map: 2x below one half, 2(1 - x) from one half up
   function automatic logic [VAL_W-1:0] tent_step(input logic [VAL_W-1:0] x);
      logic [VAL_W-1:0] d;
      d = (x < VAL_HALF) ? x : (VAL_ONE - x);
      return {d[VAL_W-2:0], 1'b0};
   endfunction

endpackage

[hw/rtl/scmg_csr.sv]
`timescale 1ns / 1ps

module scmg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  scmg_pkg::csr_index_type     csr_index,
   input  logic [31:0]                 csr_data,
   output scmg_pkg::cfg_type           cfg
);
   import scmg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAP_MODE:        cfg_in.mode           = map_mode_type'(csr_data[2:0]);
            CSR_SKEW_BREAKPOINT: cfg_in.breakpoint     = csr_data[VAL_W-1:0];
            CSR_INV_BREAKPOINT:  cfg_in.inv_breakpoint = csr_data[RECIP_W-1:0];
            CSR_INV_COMPLEMENT:  cfg_in.inv_complement = csr_data[RECIP_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_LOGISTIC;
         cfg_ff.breakpoint     <= BREAKPOINT_RESET;
         cfg_ff.inv_breakpoint <= INV_BREAKPOINT_RESET;
         cfg_ff.inv_complement <= INV_COMPLEMENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/scmg_map_core.sv]
`timescale 1ns / 1ps

module scmg_map_core (
   input  scmg_pkg::cfg_type              cfg,
   input  logic                           load,
   input  logic [scmg_pkg::VAL_W-1:0]     seed,
   input  logic [scmg_pkg::VAL_W-1:0]     x,
   input  logic                           phase,
   output logic [scmg_pkg::VAL_W-1:0]     x_next,
   output logic                           phase_next
);
   import scmg_pkg::*;

   logic [VAL_W-1:0]  tent_x;
   logic [VAL_W-1:0]  logi_in;
   logic              skew_mode;
   logic              skew_low;
   logic [VAL_W-1:0]  mul_a;
   logic [RECIP_W-1:0] mul_b;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] shifted;
   logic [VAL_W-1:0]  mul_sat;
   logic [VAL_W-1:0]  tent_of_mul;
   logic [VAL_W-1:0]  step_val;

   // one shared multiplier: logistic x(1-x) or skew-tent reciprocal product
   always_comb begin
      tent_x    = tent_step(x);
      skew_mode = (cfg.mode == MODE_SKEW_TENT);
      skew_low  = (x < cfg.breakpoint);
      logi_in   = (cfg.mode == MODE_TENT_LOGISTIC) ? tent_x : x;

      if (skew_mode) begin
         mul_a = skew_low ? x : (VAL_ONE - x);
         mul_b = skew_low ? cfg.inv_breakpoint : cfg.inv_complement;
      end else begin
         mul_a = logi_in;
         mul_b = RECIP_W'(VAL_ONE - logi_in);
      end

      product = {{(PROD_W-VAL_W){1'b0}}, mul_a} * {{(PROD_W-RECIP_W){1'b0}}, mul_b};
      shifted = skew_mode ? (product >> RECIP_SHIFT) : (product >> LOGI_SHIFT);
      mul_sat = (shifted > {{(PROD_W-VAL_W){1'b0}}, VAL_ONE}) ? VAL_ONE
                                                              : shifted[VAL_W-1:0];
      tent_of_mul = tent_step(mul_sat);

      phase_next = phase;
      case (cfg.mode)
         MODE_TENT:          step_val = tent_x;
         MODE_SKEW_TENT:     step_val = mul_sat;
         MODE_ALTERNATE: begin
            step_val   = phase ? mul_sat : tent_x;
            phase_next = ~phase;
         end
         MODE_TENT_LOGISTIC: step_val = mul_sat;
         MODE_LOGISTIC_TENT: step_val = tent_of_mul;
         default:            step_val = mul_sat;
      endcase

      if (load) begin
         x_next     = (seed > VAL_ONE) ? VAL_ONE : seed;
         phase_next = 1'b0;
      end else begin
         x_next = step_val;
      end
   end

endmodule

[hw/rtl/switched_chaotic_map_generator.sv]
`timescale 1ns / 1ps

// flow: a req transfer is captured in the input register and moves on into the
//   orbit register, which drives rsp_tvalid, once the result slot is free
// throughput: one item per cycle while rsp_tready is high; the whole map step
//   (one multiply, compares, subtracts) runs between input and orbit registers
// reset: synchronous, active high; orbit value 0, phase cleared (tent next),
//   mode logistic, breakpoint and reciprocals at their default values

module switched_chaotic_map_generator (
   input  logic        clock,
   input  logic        reset,

   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed
   input  logic        req_tuser,   // [0] load

   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] orbit_value

   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import scmg_pkg::*;

   cfg_type cfg;

   // input register stage
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             s1_load_ff;
   logic [VAL_W-1:0] s1_seed_ff;
   logic             s1_adv;

   // orbit state doubles as the result register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [VAL_W-1:0] current_value_ff;
   logic [VAL_W-1:0] current_value_in;
   logic             alternate_phase_ff;
   logic             alternate_phase_in;
   logic [VAL_W-1:0] core_value;
   logic             core_phase;

   scmg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scmg_map_core u_core (
      .cfg        (cfg),
      .load       (s1_load_ff),
      .seed       (s1_seed_ff),
      .x          (current_value_ff),
      .phase      (alternate_phase_ff),
      .x_next     (core_value),
      .phase_next (core_phase)
   );

   // item moves on when the result slot is empty or being drained
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = current_value_ff;

   always_comb begin
      s1_valid_in        = s1_valid_ff;
      rsp_valid_in       = rsp_valid_ff;
      current_value_in   = current_value_ff;
      alternate_phase_in = alternate_phase_ff;

      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // the map step commits state and result in the same edge
      if (s1_adv) begin
         rsp_valid_in       = 1'b1;
         current_value_in   = core_value;
         alternate_phase_in = core_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         current_value_ff   <= '0;
         alternate_phase_ff <= 1'b0;
      end else begin
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         current_value_ff   <= current_value_in;
         alternate_phase_ff <= alternate_phase_in;
      end
   end

   // payload of the input stage, captured on a req transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_load_ff <= req_tuser;
         s1_seed_ff <= req_tdata[VAL_W-1:0];
      end
   end

   // orbit never leaves [0, 1.0]
   a_value_in_range: assert property (@(posedge clock) disable iff (reset)
      current_value_ff <= VAL_ONE)
      else $error("orbit value above one");

   // a new result only appears after the input stage hands over an item
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv))
      else $error("result without an item from the input stage");

   // a load leaves the alternation phase cleared
   a_load_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_load_ff) |=> !alternate_phase_ff)
      else $error("phase not cleared by load");

   // a stalled item stays in the input stage
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_seed_ff)))
      else $error("stalled item lost from input stage");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

import scmg_pkg::*;

// tracks the map state and registers, predicts every orbit value in order
class orbit_scoreboard;
   logic [2:0]  mode_bits;
   logic [63:0] breakpoint;
   logic [63:0] inv_rise;
   logic [63:0] inv_fall;
   logic [63:0] orbit;
   bit          logistic_next;
   logic [31:0] predicted_orbits[$];
   int          failures;

   function new();
      mode_bits     = MODE_LOGISTIC;
      breakpoint    = 64'(BREAKPOINT_RESET);
      inv_rise      = 64'(INV_BREAKPOINT_RESET);
      inv_fall      = 64'(INV_COMPLEMENT_RESET);
      orbit         = '0;
      logistic_next = 1'b0;
      failures      = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_MAP_MODE:        mode_bits  = data[2:0];
         CSR_SKEW_BREAKPOINT: breakpoint = 64'(data);
         CSR_INV_BREAKPOINT:  inv_rise   = 64'(data);
         CSR_INV_COMPLEMENT:  inv_fall   = 64'(data);
         default: ;
      endcase
   endfunction

   // truncated product, shifted down and clamped at one
   function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int unsigned sh);
      logic [63:0] r;
      r = (a * b) >> sh;
      return (r > 64'(VAL_ONE)) ? 64'(VAL_ONE) : r;
   endfunction

   function logic [63:0] logistic_of(logic [63:0] x);
      return scaled_product(x, 64'(VAL_ONE) - x, LOGI_SHIFT);
   endfunction

   function logic [63:0] tent_of(logic [63:0] x);
      if (x < 64'(VAL_HALF)) return x << 1;
      return (64'(VAL_ONE) - x) << 1;
   endfunction

   function logic [63:0] skew_tent_of(logic [63:0] x);
      if (x < breakpoint) return scaled_product(x, inv_rise, RECIP_SHIFT);
      return scaled_product(64'(VAL_ONE) - x, inv_fall, RECIP_SHIFT);
   endfunction

   function void note_request(bit load, logic [31:0] seed);
      logic [63:0] x;
      x = orbit;
      if (load) begin
         x = (64'(seed) > 64'(VAL_ONE)) ? 64'(VAL_ONE) : 64'(seed);
         logistic_next = 1'b0;
      end else begin
         case (mode_bits)
            MODE_TENT:          x = tent_of(x);
            MODE_SKEW_TENT:     x = skew_tent_of(x);
            MODE_ALTERNATE: begin
               x = logistic_next ? logistic_of(x) : tent_of(x);
               logistic_next = ~logistic_next;
            end
            MODE_TENT_LOGISTIC: x = logistic_of(tent_of(x));
            MODE_LOGISTIC_TENT: x = tent_of(logistic_of(x));
            default:            x = logistic_of(x);
         endcase
      end
      orbit = x;
      predicted_orbits.push_back(x[31:0]);
   endfunction

   function void check_orbit(logic [31:0] got);
      logic [31:0] want;
      if (predicted_orbits.size() == 0) begin
         failures++;
         if (failures <= 10) $display("unexpected orbit transfer: got %h", got);
      end else begin
         want = predicted_orbits.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("orbit_value differs: expected %h got %h", want, got);
         end
      end
   endfunction

   function void close_out();
      if (predicted_orbits.size() != 0) begin
         failures += predicted_orbits.size();
         $display("%0d orbit values never arrived", predicted_orbits.size());
      end
   endfunction
endclass

module tb;

   // mode codes beyond the defined set, both fall back to logistic
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // [31:0] seed
   logic        req_tuser  = 1'b0;  // [0] load

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] orbit_value

   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_MAP_MODE;
   logic [31:0] csr_data   = '0;

   // no idling on either side while this is set
   bit          steady     = 1'b0;
   logic [31:0] cur_gamma  = BREAKPOINT_RESET;

   orbit_scoreboard sb = new();

   switched_chaotic_map_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // result side: check each transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_orbit(rsp_tdata);
      rsp_tready <= steady || ($urandom_range(99) >= 16);
   end

   // one request transfer; valid stays high on return for back-to-back items
   task automatic send_item(bit load, logic [31:0] seed);
      while (!steady && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seed;
      req_tuser  <= load;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(load, seed);
   endtask

   // register write; the caller drops csr_valid after its last write
   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      if (idx == CSR_SKEW_BREAKPOINT) cur_gamma = data;
   endtask

   task automatic set_mode(logic [2:0] m);
      write_reg(CSR_MAP_MODE, 32'(m));
      csr_valid <= 1'b0;
   endtask

   // stop sending and let every predicted value come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.predicted_orbits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // seeds biased to the branch edges and fixed points
   function automatic logic [31:0] pick_seed();
      case ($urandom_range(9))
         0:       return '0;
         1:       return VAL_ONE;
         2:       return VAL_HALF;
         3:       return VAL_HALF + 32'($urandom_range(1)) - 32'($urandom_range(1));
         4:       return cur_gamma;
         5:       return cur_gamma - 1;
         6:       return $urandom();                      // may exceed one
         7:       return VAL_ONE - 32'($urandom_range(3));
         default: return $urandom_range(VAL_ONE);
      endcase
   endfunction

   // one setting of all four registers, then a run of random transfers
   task automatic run_setting(logic [2:0] m, logic [31:0] g, logic [31:0] ib,
                              logic [31:0] ic, int count, bit no_idle);
      bit          load;
      logic [31:0] seed;
      drain();
      write_reg(CSR_MAP_MODE, 32'(m));
      write_reg(CSR_SKEW_BREAKPOINT, g);
      write_reg(CSR_INV_BREAKPOINT, ib);
      write_reg(CSR_INV_COMPLEMENT, ic);
      csr_valid <= 1'b0;
      steady = no_idle;
      for (int i = 0; i < count; i++) begin
         // frequent reloads, fixed-point orbits tend to collapse to zero
         load = ($urandom_range(4) == 0);
         seed = load ? pick_seed() : $urandom();
         send_item(load, seed);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset registers: logistic, advance from the zero state first
      send_item(1'b0, 32'hFFFF_FFFF);
      send_item(1'b1, 32'hFFFF_FFFF);   // seed above one clamps
      send_item(1'b0, '0);              // logistic of one falls to zero
      send_item(1'b1, 32'h8000_0001);
      send_item(1'b1, VAL_ONE);
      send_item(1'b1, '0);
      send_item(1'b1, VAL_HALF);
      send_item(1'b0, 32'h5555_5555);   // peak of the parabola saturates
      drain();

      set_mode(MODE_TENT);
      send_item(1'b1, VAL_HALF);
      send_item(1'b0, '0);
      drain();

      // skew tent on both sides of the breakpoint
      set_mode(MODE_SKEW_TENT);
      send_item(1'b1, BREAKPOINT_RESET);
      send_item(1'b0, '0);
      send_item(1'b1, BREAKPOINT_RESET - 1);
      send_item(1'b0, '0);
      drain();

      // alternation: tent, logistic, then a load restarts on tent
      set_mode(MODE_ALTERNATE);
      send_item(1'b1, 32'h2AAA_AAAA);
      send_item(1'b0, '0);
      send_item(1'b0, '0);
      send_item(1'b1, 32'h1234_5678);
      send_item(1'b0, '0);
      drain();

      set_mode(MODE_TENT_LOGISTIC);
      send_item(1'b1, 32'h1999_9999);
      send_item(1'b0, '0);
      drain();

      set_mode(MODE_LOGISTIC_TENT);
      send_item(1'b1, 32'h6666_6666);
      send_item(1'b0, '0);
      drain();

      // unused codes act as logistic
      set_mode(MODE_SPARE_LO);
      send_item(1'b1, 32'h3000_0000);
      send_item(1'b0, '0);
      drain();
      set_mode(MODE_SPARE_HI);
      send_item(1'b0, '0);

      // random part, one setting per run
      run_setting(MODE_LOGISTIC, BREAKPOINT_RESET, INV_BREAKPOINT_RESET,
                  INV_COMPLEMENT_RESET, 60, 1'b0);
      run_setting(MODE_TENT, $urandom(), $urandom(), $urandom(), 60, 1'b1);
      run_setting(MODE_SKEW_TENT, BREAKPOINT_RESET, INV_BREAKPOINT_RESET,
                  INV_COMPLEMENT_RESET, 70, 1'b0);
      // zero breakpoint: every value takes the falling branch
      run_setting(MODE_SKEW_TENT, '0, '0, 32'hFFFF_FFFF, 50, 1'b0);
      run_setting(MODE_SKEW_TENT, VAL_ONE, 32'hFFFF_FFFF, '0, 50, 1'b0);
      // breakpoint above one: every value takes the rising branch
      run_setting(MODE_SKEW_TENT, 32'hFFFF_FFFF, 32'h1000_0000, $urandom(), 50, 1'b0);
      run_setting(MODE_SKEW_TENT, $urandom_range(VAL_ONE - 1, 1), $urandom(), $urandom(),
                  60, 1'b0);
      run_setting(MODE_ALTERNATE, $urandom(), $urandom(), $urandom(), 70, 1'b0);
      run_setting(MODE_TENT_LOGISTIC, $urandom(), $urandom(), $urandom(), 60, 1'b0);
      run_setting(MODE_LOGISTIC_TENT, $urandom(), $urandom(), $urandom(), 60, 1'b0);
      run_setting(MODE_SPARE_LO, $urandom(), $urandom(), $urandom(), 30, 1'b0);
      run_setting(MODE_SPARE_HI, $urandom(), $urandom(), $urandom(), 30, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/scmg_pkg.sv
hw/rtl/scmg_csr.sv
hw/rtl/scmg_map_core.sv
hw/rtl/switched_chaotic_map_generator.sv
bench/tb.sv
